@@ sv/imu_gbcs_pkg.sv @@
// Package with the types, field widths and scaling constants of the gyro bias calibration block.
`default_nettype none
package imu_gbcs_pkg;

  localparam int AXES              = 3;
  localparam int RAW_W             = 16;
  localparam int ACCEL_W           = 15;
  localparam int TURN_W            = 23;
  localparam int CNT_W             = 8;
  localparam int SUM_W             = 24;
  localparam int CALIB_SAMPLES_DEF = 64;

  localparam int IN_TDATA_W  = 2 * AXES * RAW_W;
  localparam int OUT_TDATA_W = 128;
  localparam int TURN_POS    = AXES * ACCEL_W;
  localparam int CAL_POS     = TURN_POS + AXES * TURN_W;
  localparam int CNT_POS     = CAL_POS + 1;

  localparam logic signed [10:0] ACC_SCALE  = 11'sd1000;
  localparam int                 ACC_SHIFT  = 11;
  localparam logic signed [14:0] RATE_SCALE = 15'sd10000;

  localparam int PROD_W   = 31;
  localparam int TURN_DIV = 164;
  localparam int TURN_SHIFT = (PROD_W - 1) + 8;
  localparam longint unsigned TURN_RECIP_FULL =
    ((64'd1 << TURN_SHIFT) + 64'(TURN_DIV) - 64'd1) / 64'(TURN_DIV);
  localparam logic [30:0] TURN_RECIP = 31'(TURN_RECIP_FULL);

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef logic signed [ACCEL_W-1:0] accel_t;
  typedef logic signed [TURN_W-1:0]  turn_t;

  typedef struct packed {
    logic             restart;
    logic             last;
    logic             cal;
    logic [CNT_W-1:0] cnt;
  } stage_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
    logic load4;
    logic sum_clear;
    logic sum_add;
    logic r1_restart;
    logic r1_last;
    logic r3_turn_upd;
  } lane_ctl_t;

endpackage
`default_nettype wire

@@ sv/imu_gbcs_lane.sv @@
// One axis lane: acceleration scaling, gyro sum, bias division and rate scaling.
`default_nettype none
module imu_gbcs_lane #(
  parameter int CALIBRATION_SAMPLES = imu_gbcs_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imu_gbcs_pkg::lane_ctl_t     ctl,
  input  logic signed [15:0]          acc_raw,
  input  logic signed [15:0]          rate_raw,
  output imu_gbcs_pkg::accel_t        accel_mg,
  output imu_gbcs_pkg::turn_t         turn
);

  localparam int SUM_W        = imu_gbcs_pkg::SUM_W;
  localparam int BIAS_SHIFT   = SUM_W + $clog2(CALIBRATION_SAMPLES);
  localparam int BIAS_RECIP_W = SUM_W + 2;
  localparam longint unsigned BIAS_RECIP_FULL =
    ((64'd1 << BIAS_SHIFT) + 64'(CALIBRATION_SAMPLES) - 64'd1) / 64'(CALIBRATION_SAMPLES);
  localparam logic [BIAS_RECIP_W-1:0] BIAS_RECIP = BIAS_RECIP_W'(BIAS_RECIP_FULL);

  logic signed [SUM_W-1:0]               sum_r;
  logic signed [15:0]                    acc1_r;
  logic signed [15:0]                    rate1_r;
  imu_gbcs_pkg::accel_t                  accel2_r;
  logic signed [15:0]                    rate2_r;
  logic signed [15:0]                    bias_r;
  logic signed [imu_gbcs_pkg::PROD_W-1:0] prod3_r;
  imu_gbcs_pkg::accel_t                  accel3_r;
  imu_gbcs_pkg::turn_t                   last_turn_r;

  logic                                  sum_neg;
  logic [SUM_W-1:0]                      sum_mag;
  logic [SUM_W+BIAS_RECIP_W-1:0]         bias_prod;
  logic [16:0]                           bias_quo;
  logic [16:0]                           bias_sgn;
  logic signed [25:0]                    acc_prod;
  logic signed [25:0]                    acc_adj;
  imu_gbcs_pkg::accel_t                  accel_l1;
  logic signed [16:0]                    corr;
  logic signed [imu_gbcs_pkg::PROD_W-1:0] corr_prod;
  logic                                  p_neg;
  logic [imu_gbcs_pkg::PROD_W-2:0]       p_mag;
  logic [2*imu_gbcs_pkg::PROD_W-2:0]     turn_prod;
  logic [21:0]                           turn_quo;
  imu_gbcs_pkg::turn_t                   turn_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.sum_clear) begin
      sum_r <= '0;
    end else if (ctl.sum_add) begin
      sum_r <= sum_r + SUM_W'(rate_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      acc1_r  <= acc_raw;
      rate1_r <= rate_raw;
    end
  end

  // Truncating division of the sum by the sample count via an exact reciprocal.
  assign sum_neg   = sum_r[SUM_W-1];
  assign sum_mag   = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign bias_prod = sum_mag * BIAS_RECIP;
  assign bias_quo  = 17'(bias_prod >> BIAS_SHIFT);
  assign bias_sgn  = sum_neg ? (17'd0 - bias_quo) : bias_quo;

  assign acc_prod = acc1_r * imu_gbcs_pkg::ACC_SCALE;
  assign acc_adj  = acc_prod + (acc_prod[25] ? 26'sd2047 : 26'sd0);
  assign accel_l1 = acc_adj[25:imu_gbcs_pkg::ACC_SHIFT];

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      accel2_r <= ctl.r1_restart ? '0 : accel_l1;
      rate2_r  <= rate1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (ctl.load2 && ctl.r1_restart) begin
      bias_r <= '0;
    end else if (ctl.load2 && ctl.r1_last) begin
      bias_r <= bias_sgn[15:0];
    end
  end

  assign corr      = 17'(rate2_r) - 17'(bias_r);
  assign corr_prod = corr * imu_gbcs_pkg::RATE_SCALE;

  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      prod3_r  <= corr_prod;
      accel3_r <= accel2_r;
    end
  end

  assign p_neg     = prod3_r[imu_gbcs_pkg::PROD_W-1];
  assign p_mag     = p_neg ? (imu_gbcs_pkg::PROD_W-1)'(-prod3_r)
                           : prod3_r[imu_gbcs_pkg::PROD_W-2:0];
  assign turn_prod = p_mag * imu_gbcs_pkg::TURN_RECIP;
  assign turn_quo  = 22'(turn_prod >> imu_gbcs_pkg::TURN_SHIFT);
  assign turn_new  = p_neg ? (23'd0 - {1'b0, turn_quo}) : {1'b0, turn_quo};

  assign turn     = ctl.r3_turn_upd ? turn_new : last_turn_r;
  assign accel_mg = accel3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_turn_r <= '0;
    end else if (ctl.load4) begin
      last_turn_r <= turn;
    end
  end

endmodule
`default_nettype wire

@@ sv/imu_gbcs_merge.sv @@
// Merging stage: gathers the lane results and status into the registered output request.
`default_nettype none
module imu_gbcs_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  out_tready,
  input  imu_gbcs_pkg::stage_t                  stat,
  input  imu_gbcs_pkg::accel_t                  accel [imu_gbcs_pkg::AXES],
  input  imu_gbcs_pkg::turn_t                   turn  [imu_gbcs_pkg::AXES],
  output logic                                  out_tvalid,
  output logic [imu_gbcs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                                 out_tvalid_r;
  logic [imu_gbcs_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [imu_gbcs_pkg::OUT_TDATA_W-1:0] word;

  always_comb begin
    word = '0;
    for (int g = 0; g < imu_gbcs_pkg::AXES; g++) begin
      word[imu_gbcs_pkg::ACCEL_W*g +: imu_gbcs_pkg::ACCEL_W] = accel[g];
      word[imu_gbcs_pkg::TURN_POS + imu_gbcs_pkg::TURN_W*g +: imu_gbcs_pkg::TURN_W] = turn[g];
    end
    word[imu_gbcs_pkg::CAL_POS] = stat.cal;
    word[imu_gbcs_pkg::CNT_POS +: imu_gbcs_pkg::CNT_W] = stat.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= word;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

@@ sv/imu_gyro_bias_calibrate_scale.sv @@
// Top level of the gyro bias calibration and scaling block.
// A request passes the stage 1, 2 and 3 registers, then the out_tvalid output register.
// Throughput: one request per cycle unless stalled; three lanes run the four-stage datapath.
// Stalls propagate stage by stage, so empty stages still take requests while a result waits.
// Reset clears the pipeline valids, gyro sums, biases, sample count, calibrated flag
// and the held rate outputs; it takes effect in the cycle it is applied.
`default_nettype none
module imu_gyro_bias_calibrate_scale #(
  parameter int CALIBRATION_SAMPLES = imu_gbcs_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z
  input  logic [imu_gbcs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode
  input  logic [0:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // accel_x/y/z_milli_g, turn_x/y/z_milli_dps, is_calibrated, samples_collected, zero pad
  output logic [imu_gbcs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CNT_W = imu_gbcs_pkg::CNT_W;
  localparam logic [CNT_W-1:0] N_SAMPLES = CNT_W'(CALIBRATION_SAMPLES);

  logic [CNT_W-1:0]        cnt_r;
  logic                    cal_r;
  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  imu_gbcs_pkg::stage_t    st1_r;
  imu_gbcs_pkg::stage_t    st2_r;
  imu_gbcs_pkg::stage_t    st3_r;

  logic                    in_restart;
  logic                    sample_take;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    last;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    cal_nxt;
  logic                    free1;
  logic                    free2;
  logic                    free3;
  logic                    free4;
  imu_gbcs_pkg::lane_ctl_t ctl;
  imu_gbcs_pkg::accel_t    accel [imu_gbcs_pkg::AXES];
  imu_gbcs_pkg::turn_t     turn  [imu_gbcs_pkg::AXES];

  assign free4 = !out_tvalid || out_tready;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_tready = free1;

  assign in_restart  = (in_tuser[0] == imu_gbcs_pkg::OP_RESTART);
  assign sample_take = !in_restart && (cnt_r < N_SAMPLES);
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign last        = sample_take && (cnt_inc == N_SAMPLES);
  assign cnt_nxt     = in_restart ? '0 : (sample_take ? cnt_inc : cnt_r);
  assign cal_nxt     = in_restart ? 1'b0 : (last ? 1'b1 : cal_r);

  always_comb begin
    ctl.load1       = in_tvalid && free1;
    ctl.load2       = v1_r && free2;
    ctl.load3       = v2_r && free3;
    ctl.load4       = v3_r && free4;
    ctl.sum_clear   = ctl.load1 && in_restart;
    ctl.sum_add     = ctl.load1 && sample_take;
    ctl.r1_restart  = st1_r.restart;
    ctl.r1_last     = st1_r.last;
    ctl.r3_turn_upd = !st3_r.restart && st3_r.cal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cal_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (ctl.load1) begin
        cnt_r <= cnt_nxt;
        cal_r <= cal_nxt;
      end
      v1_r <= ctl.load1 || (v1_r && !ctl.load2);
      v2_r <= ctl.load2 || (v2_r && !ctl.load3);
      v3_r <= ctl.load3 || (v3_r && !ctl.load4);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      st1_r <= '{restart: in_restart, last: last, cal: cal_nxt, cnt: cnt_nxt};
    end
    if (ctl.load2) begin
      st2_r <= st1_r;
    end
    if (ctl.load3) begin
      st3_r <= st2_r;
    end
  end

  for (genvar g = 0; g < imu_gbcs_pkg::AXES; g++) begin : g_lane
    imu_gbcs_lane #(
      .CALIBRATION_SAMPLES(CALIBRATION_SAMPLES)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .acc_raw  (in_tdata[imu_gbcs_pkg::RAW_W*g +: imu_gbcs_pkg::RAW_W]),
      .rate_raw (in_tdata[imu_gbcs_pkg::RAW_W*(g + imu_gbcs_pkg::AXES) +:
                          imu_gbcs_pkg::RAW_W]),
      .accel_mg (accel[g]),
      .turn     (turn[g])
    );
  end

  imu_gbcs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.load4),
    .out_tready (out_tready),
    .stat       (st3_r),
    .accel      (accel),
    .turn       (turn),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
